@@ sv/brvm_pkg.sv @@
package brvm_pkg;

	localparam int NUM_REGS_DEF = 16;

	typedef enum logic [4:0] {
		CMD_ADD   = 5'd0,
		CMD_SUB   = 5'd1,
		CMD_MUL   = 5'd2,
		CMD_DIV   = 5'd3,
		CMD_MOD   = 5'd4,
		CMD_EQ    = 5'd5,
		CMD_LT    = 5'd6,
		CMD_GT    = 5'd7,
		CMD_LE    = 5'd8,
		CMD_GE    = 5'd9,
		CMD_CONST = 5'd10,
		CMD_SEXT  = 5'd11,
		CMD_ZEXT  = 5'd12,
		CMD_JT    = 5'd13,
		CMD_JF    = 5'd14,
		CMD_JUMP  = 5'd15,
		CMD_HALT  = 5'd16
	} cmd_t;

	typedef struct packed {
		logic [4:0]  command;
		logic [1:0]  width_code;
		logic [1:0]  source_width_code;
		logic        is_signed;
		logic [3:0]  dest_reg;
		logic [3:0]  src1_reg;
		logic [3:0]  src2_reg;
		logic [63:0] immediate;
	} instr_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture instruction and operands
		logic exec;      // execute and writeback, except for mul, div and mod
		logic div_start;
		logic div_step;
		logic div_done;  // write back mul, div or mod result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_div;
		logic div_last;
	} dp_sts_t;

	function automatic logic [63:0] width_mask(input logic [1:0] code);
		case (code)
			2'd0: width_mask = 64'h0000_0000_0000_00ff;
			2'd1: width_mask = 64'h0000_0000_0000_ffff;
			2'd2: width_mask = 64'h0000_0000_ffff_ffff;
			default: width_mask = '1;
		endcase
	endfunction

	function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [1:0] code);
		case (code)
			2'd0: sign_ext = {{56{v[7]}}, v[7:0]};
			2'd1: sign_ext = {{48{v[15]}}, v[15:0]};
			2'd2: sign_ext = {{32{v[31]}}, v[31:0]};
			default: sign_ext = v;
		endcase
	endfunction

	function automatic logic [3:0] instr_len(input logic [4:0] cmd, input logic [1:0] wc);
		if (cmd <= CMD_GE) instr_len = 4'd4;
		else if (cmd == CMD_CONST) instr_len = 4'd2 + (4'd1 << wc);
		else if (cmd == CMD_SEXT || cmd == CMD_ZEXT) instr_len = 4'd3;
		else if (cmd == CMD_JT || cmd == CMD_JF) instr_len = 4'd10;
		else if (cmd == CMD_JUMP) instr_len = 4'd9;
		else instr_len = 4'd1;
	endfunction

endpackage

@@ sv/brvm_datapath.sv @@
module brvm_datapath #(
	parameter int NUM_REGS = brvm_pkg::NUM_REGS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  brvm_pkg::instr_t  instr,
	input  logic [15:0]       program_length,
	input  brvm_pkg::dp_cmd_t cmd,
	output brvm_pkg::dp_sts_t sts,
	output logic [63:0]       ip,
	output logic              halted,
	output logic              error
);
	localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	logic [NUM_REGS-1:0][63:0] rf_q;
	brvm_pkg::instr_t ins_q;
	logic [63:0] a_q, b_q, r1_q, rd_q;
	logic [63:0] ip_q;
	logic halted_q, error_q, run_q;

	// divider and multiplier state
	logic [63:0] dq_q, drem_q, dmb_q, dma_q;
	logic [6:0]  dcnt_q;
	logic        dzero_q, dna_q, dnq_q;

	function automatic logic [63:0] rd_reg(input logic [NUM_REGS-1:0][63:0] rf,
	                                       input logic [3:0] idx);
		logic [63:0] v;
		v = '0;
		if ({28'd0, idx} < NUM_REGS) v = rf[IW'(idx)];
		return v;
	endfunction

	logic [63:0] m, wval, nxt;
	logic [63:0] ka, kb, sa, sb;
	logic        wen, oob, is_mul;
	logic [3:0]  len;
	logic [64:0] trial;
	logic [63:0] ql, rl;

	always_comb begin
		m = brvm_pkg::width_mask(ins_q.width_code);
		len = brvm_pkg::instr_len(ins_q.command, ins_q.width_code);
		oob = (ip_q > {48'd0, program_length}) ||
			(({48'd0, program_length} - ip_q) < {60'd0, len});
		ka = a_q;
		kb = b_q;
		if (ins_q.is_signed) begin
			ka = brvm_pkg::sign_ext(a_q, ins_q.width_code) ^ {1'b1, 63'd0};
			kb = brvm_pkg::sign_ext(b_q, ins_q.width_code) ^ {1'b1, 63'd0};
		end
		wen = 1'b1;
		wval = '0;
		nxt = ip_q + {60'd0, len};
		case (ins_q.command)
			brvm_pkg::CMD_ADD:   wval = a_q + b_q;
			brvm_pkg::CMD_SUB:   wval = a_q - b_q;
			brvm_pkg::CMD_EQ:    wval = {63'd0, a_q == b_q};
			brvm_pkg::CMD_LT:    wval = {63'd0, ka < kb};
			brvm_pkg::CMD_GT:    wval = {63'd0, ka > kb};
			brvm_pkg::CMD_LE:    wval = {63'd0, ka <= kb};
			brvm_pkg::CMD_GE:    wval = {63'd0, ka >= kb};
			brvm_pkg::CMD_CONST: wval = ins_q.immediate;
			brvm_pkg::CMD_SEXT:  wval = brvm_pkg::sign_ext(r1_q, ins_q.source_width_code);
			brvm_pkg::CMD_ZEXT:  wval = r1_q & brvm_pkg::width_mask(ins_q.source_width_code);
			brvm_pkg::CMD_JT: begin
				wen = 1'b0;
				if (rd_q[7:0] != 8'd0) nxt = ins_q.immediate;
			end
			brvm_pkg::CMD_JF: begin
				wen = 1'b0;
				if (rd_q[7:0] == 8'd0) nxt = ins_q.immediate;
			end
			brvm_pkg::CMD_JUMP: begin
				wen = 1'b0;
				nxt = ins_q.immediate;
			end
			default: wen = 1'b0;
		endcase
		// restoring divide, one quotient bit per step
		trial = {drem_q, dma_q[63]} - {1'b0, dmb_q};
		ql = dnq_q ? (64'd0 - dq_q) : dq_q;
		rl = dna_q ? (64'd0 - drem_q) : drem_q;
		sa = brvm_pkg::sign_ext(a_q, ins_q.width_code);
		sb = brvm_pkg::sign_ext(b_q, ins_q.width_code);
	end

	assign is_mul = ins_q.command == brvm_pkg::CMD_MUL;

	// mul, div and mod run on the step counter
	assign sts.is_div = run_q && !oob && (is_mul ||
		ins_q.command == brvm_pkg::CMD_DIV || ins_q.command == brvm_pkg::CMD_MOD);
	assign sts.div_last = dcnt_q == 7'd63;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ins_q <= instr;
			a_q  <= rd_reg(rf_q, instr.src1_reg) & brvm_pkg::width_mask(instr.width_code);
			b_q  <= rd_reg(rf_q, instr.src2_reg) & brvm_pkg::width_mask(instr.width_code);
			r1_q <= rd_reg(rf_q, instr.src1_reg);
			rd_q <= rd_reg(rf_q, instr.dest_reg);
		end
		if (cmd.div_start) begin
			dzero_q <= b_q == 64'd0;
			dna_q <= ins_q.is_signed && sa[63];
			dnq_q <= ins_q.is_signed && (sa[63] ^ sb[63]);
			if (is_mul) begin
				dma_q <= a_q;
				dmb_q <= b_q;
			end else begin
				dma_q <= (ins_q.is_signed && sa[63]) ? 64'd0 - sa : a_q;
				dmb_q <= (ins_q.is_signed && sb[63]) ? 64'd0 - sb : b_q;
			end
			dq_q <= '0;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			dma_q <= {dma_q[62:0], 1'b0};
			if (is_mul) begin
				// shift-add multiply, low product bits gather in dq_q
				dmb_q <= {1'b0, dmb_q[63:1]};
				if (dmb_q[0]) dq_q <= dq_q + dma_q;
			end else if (!trial[64]) begin
				drem_q <= trial[63:0];
				dq_q <= {dq_q[62:0], 1'b1};
			end else begin
				drem_q <= {drem_q[62:0], dma_q[63]};
				dq_q <= {dq_q[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q <= '0;
			ip_q <= '0;
			halted_q <= 1'b0;
			error_q <= 1'b0;
			run_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load) run_q <= !halted_q && !error_q;
			if (cmd.div_start) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + 7'd1;
			if (cmd.exec && run_q) begin
				if (oob) begin
					error_q <= 1'b1;
				end else if (!sts.is_div) begin
					ip_q <= nxt;
					if (ins_q.command == brvm_pkg::CMD_HALT) halted_q <= 1'b1;
					if (ins_q.command > brvm_pkg::CMD_HALT) error_q <= 1'b1;
					if (wen && {28'd0, ins_q.dest_reg} < NUM_REGS)
						rf_q[IW'(ins_q.dest_reg)] <= (rf_q[IW'(ins_q.dest_reg)] & ~m) |
							(wval & m);
				end
			end
			if (cmd.div_done) begin
				ip_q <= nxt;
				if ({28'd0, ins_q.dest_reg} < NUM_REGS)
					rf_q[IW'(ins_q.dest_reg)] <= (rf_q[IW'(ins_q.dest_reg)] & ~m) |
						((is_mul ? dq_q : (ins_q.command == brvm_pkg::CMD_DIV) ?
						(dzero_q ? m : ql) : (dzero_q ? a_q : rl)) & m);
			end
		end
	end

	assign ip = ip_q;
	assign halted = halted_q;
	assign error = error_q;

	a_div_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> sts.is_div) else $error("divide started without divide");
	a_sticky_halt: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halted flag cleared");
	a_sticky_err: assert property (@(posedge clk) disable iff (!arst_n)
		error_q |=> error_q) else $error("error flag cleared");
endmodule

@@ sv/brvm_ctrl.sv @@
module brvm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  brvm_pkg::dp_sts_t sts,
	output brvm_pkg::dp_cmd_t cmd
);
	typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_DSTEP, ST_DDONE, ST_OUT} state_t;
	state_t state_q;

	// a new word is taken while idle, or in the cycle the result word leaves
	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_OUT && out_ready);
	assign out_valid = state_q == ST_OUT;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.exec = state_q == ST_EXEC;
		cmd.div_start = state_q == ST_EXEC && sts.is_div;
		cmd.div_step = state_q == ST_DSTEP;
		cmd.div_done = state_q == ST_DDONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_EXEC;
				ST_EXEC: state_q <= sts.is_div ? ST_DSTEP : ST_OUT;
				ST_DSTEP: if (sts.div_last) state_q <= ST_DDONE;
				ST_DDONE: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) state_q <= in_valid ? ST_EXEC : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSTEP) |-> !cmd.load) else $error("load during divide");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result word dropped");
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_EXEC)) else $error("loaded word not executed");
endmodule

@@ sv/bytecode_register_vm_execute.sv @@
// flow: an accepted word is loaded, passes the execute state and then waits in the output state;
// mul, div and mod add 64 steps of one bit per cycle and a writeback state before output
// a new word is taken only while idle or as the previous result word leaves, never mid-execution
// reset: arst_n clears registers, instruction pointer, flags and program_length
module bytecode_register_vm_execute #(
	parameter int NUM_REGS = brvm_pkg::NUM_REGS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command, width_code, source_width_code, is_signed, dest_reg, src1_reg,
	// src2_reg, immediate
	input  logic [87:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// next_ip, halted, error
	output logic [71:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);
	brvm_pkg::instr_t  instr;
	brvm_pkg::dp_cmd_t cmd;
	brvm_pkg::dp_sts_t sts;
	logic [15:0] plen_q;
	logic [63:0] ip;
	logic halted, error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) plen_q <= '0;
		else if (cfg_we) plen_q <= cfg_wdata;
	end

	assign instr.command           = s_tdata[4:0];
	assign instr.width_code        = s_tdata[6:5];
	assign instr.source_width_code = s_tdata[8:7];
	assign instr.is_signed         = s_tdata[9];
	assign instr.dest_reg          = s_tdata[13:10];
	assign instr.src1_reg          = s_tdata[17:14];
	assign instr.src2_reg          = s_tdata[21:18];
	assign instr.immediate         = s_tdata[85:22];

	brvm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .sts(sts), .cmd(cmd)
	);

	brvm_datapath #(.NUM_REGS(NUM_REGS)) u_dp (
		.clk(clk), .arst_n(arst_n), .instr(instr), .program_length(plen_q),
		.cmd(cmd), .sts(sts), .ip(ip), .halted(halted), .error(error)
	);

	assign m_tdata = {6'd0, error, halted, ip};
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam logic [4:0] CMD_ILLEGAL = 5'd17;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [63:0] next_ip;
		logic        halted;
		logic        error;
	} vm_status_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [87:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic         cfg_we;
	logic [15:0]  cfg_wdata;

	bytecode_register_vm_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// shadow machine state
	logic [63:0] regs [16];
	logic [63:0] vm_ip;
	logic        vm_halt;
	logic        vm_err;
	logic [63:0] prog_len;

	brvm_pkg::instr_t instr_q[$];
	vm_status_t  status_q[$];
	int          errors;
	int          stall_cnt;

	function automatic logic [63:0] lane_mask(logic [1:0] code);
		if (code == 2'd3)
			return '1;
		return (64'd1 << (8 << code)) - 64'd1;
	endfunction

	function automatic logic [63:0] sext_lane(logic [63:0] v, logic [1:0] code);
		logic [63:0] m;
		m = lane_mask(code);
		if (code == 2'd3)
			return v;
		v = v & m;
		if (v[(8 << code) - 1])
			v = v | ~m;
		return v;
	endfunction

	function automatic logic [63:0] opcode_bytes(logic [4:0] cmd, logic [1:0] wc);
		if (cmd <= brvm_pkg::CMD_GE) return 64'd4;
		if (cmd == brvm_pkg::CMD_CONST) return 64'd2 + (64'd1 << wc);
		if (cmd == brvm_pkg::CMD_SEXT || cmd == brvm_pkg::CMD_ZEXT) return 64'd3;
		if (cmd == brvm_pkg::CMD_JT || cmd == brvm_pkg::CMD_JF) return 64'd10;
		if (cmd == brvm_pkg::CMD_JUMP) return 64'd9;
		return 64'd1;
	endfunction

	function automatic void reg_store(logic [3:0] idx, logic [63:0] v, logic [1:0] wc);
		logic [63:0] m;
		m = lane_mask(wc);
		regs[idx] = (regs[idx] & ~m) | (v & m);
	endfunction

	function automatic void div_rem(logic [63:0] a, logic [63:0] b, logic [1:0] wc, logic sgn,
			output logic [63:0] q, output logic [63:0] r);
		logic [63:0] m, ma, mb, qq, rr;
		logic na, nb;
		m = lane_mask(wc);
		a = a & m;
		b = b & m;
		na = 1'b0;
		nb = 1'b0;
		if (b == 0) begin
			q = m;
			r = a;
			return;
		end
		if (sgn) begin
			a = sext_lane(a, wc);
			b = sext_lane(b, wc);
			na = a[63];
			nb = b[63];
		end
		ma = na ? -a : a;
		mb = nb ? -b : b;
		qq = ma / mb;
		rr = ma % mb;
		if (na != nb) qq = -qq;
		if (na) rr = -rr;
		q = qq & m;
		r = rr & m;
	endfunction

	// applies one instruction to the shadow state and returns the status word
	function automatic vm_status_t execute_instr(brvm_pkg::instr_t i);
		vm_status_t st;
		logic [63:0] len, nxt, m, a, b, ka, kb, q, r;
		if (!vm_halt && !vm_err) begin
			len = opcode_bytes(i.command, i.width_code);
			if (vm_ip > prog_len || prog_len - vm_ip < len) begin
				vm_err = 1'b1;
			end else begin
				nxt = vm_ip + len;
				m = lane_mask(i.width_code);
				a = regs[i.src1_reg] & m;
				b = regs[i.src2_reg] & m;
				ka = a;
				kb = b;
				if (i.is_signed && i.command >= brvm_pkg::CMD_LT &&
						i.command <= brvm_pkg::CMD_GE) begin
					ka = sext_lane(a, i.width_code) ^ (64'd1 << 63);
					kb = sext_lane(b, i.width_code) ^ (64'd1 << 63);
				end
				case (i.command)
					brvm_pkg::CMD_ADD: reg_store(i.dest_reg, a + b, i.width_code);
					brvm_pkg::CMD_SUB: reg_store(i.dest_reg, a - b, i.width_code);
					brvm_pkg::CMD_MUL: reg_store(i.dest_reg, a * b, i.width_code);
					brvm_pkg::CMD_DIV: begin
						div_rem(a, b, i.width_code, i.is_signed, q, r);
						reg_store(i.dest_reg, q, i.width_code);
					end
					brvm_pkg::CMD_MOD: begin
						div_rem(a, b, i.width_code, i.is_signed, q, r);
						reg_store(i.dest_reg, r, i.width_code);
					end
					brvm_pkg::CMD_EQ: reg_store(i.dest_reg, {63'd0, a == b}, i.width_code);
					brvm_pkg::CMD_LT: reg_store(i.dest_reg, {63'd0, ka < kb}, i.width_code);
					brvm_pkg::CMD_GT: reg_store(i.dest_reg, {63'd0, ka > kb}, i.width_code);
					brvm_pkg::CMD_LE: reg_store(i.dest_reg, {63'd0, ka <= kb}, i.width_code);
					brvm_pkg::CMD_GE: reg_store(i.dest_reg, {63'd0, ka >= kb}, i.width_code);
					brvm_pkg::CMD_CONST: reg_store(i.dest_reg, i.immediate, i.width_code);
					brvm_pkg::CMD_SEXT: reg_store(i.dest_reg,
						sext_lane(regs[i.src1_reg], i.source_width_code), i.width_code);
					brvm_pkg::CMD_ZEXT: reg_store(i.dest_reg,
						regs[i.src1_reg] & lane_mask(i.source_width_code), i.width_code);
					brvm_pkg::CMD_JT: if (regs[i.dest_reg][7:0] != 0) nxt = i.immediate;
					brvm_pkg::CMD_JF: if (regs[i.dest_reg][7:0] == 0) nxt = i.immediate;
					brvm_pkg::CMD_JUMP: nxt = i.immediate;
					brvm_pkg::CMD_HALT: vm_halt = 1'b1;
					default: vm_err = 1'b1;
				endcase
				vm_ip = nxt;
			end
		end
		st.next_ip = vm_ip;
		st.halted = vm_halt;
		st.error = vm_err;
		return st;
	endfunction

	function automatic brvm_pkg::instr_t make_instr(logic [4:0] cmd, logic [1:0] wc,
			logic [1:0] swc, logic sgn, logic [3:0] rd, logic [3:0] r1, logic [3:0] r2,
			logic [63:0] imm);
		brvm_pkg::instr_t i;
		i.command = cmd;
		i.width_code = wc;
		i.source_width_code = swc;
		i.is_signed = sgn;
		i.dest_reg = rd;
		i.src1_reg = r1;
		i.src2_reg = r2;
		i.immediate = imm;
		return i;
	endfunction

	function automatic void send(brvm_pkg::instr_t i);
		instr_q.push_back(i);
		status_q.push_back(execute_instr(i));
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// well-formed random instruction that keeps the pointer inside the program
	function automatic brvm_pkg::instr_t rand_instr();
		brvm_pkg::instr_t i;
		int pick;
		i = make_instr($urandom_range(0, 9), $urandom_range(0, 3), $urandom_range(0, 3),
			$urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 15), rand64());
		pick = $urandom_range(0, 99);
		if (pick < 20)
			i.command = brvm_pkg::CMD_CONST;
		else if (pick < 35)
			i.command = ($urandom_range(0, 1) != 0) ? brvm_pkg::CMD_DIV : brvm_pkg::CMD_MOD;
		else if (pick < 80)
			i.command = i.command;
		else if (pick < 88)
			i.command = ($urandom_range(0, 1) != 0) ? brvm_pkg::CMD_SEXT : brvm_pkg::CMD_ZEXT;
		else if (pick < 97)
			i.command = ($urandom_range(0, 1) != 0) ? brvm_pkg::CMD_JT : brvm_pkg::CMD_JF;
		else
			i.command = brvm_pkg::CMD_JUMP;
		if (i.command >= brvm_pkg::CMD_JT)
			i.immediate = $urandom_range(0, 4000);
		if (vm_ip + 64'd200 > prog_len) begin
			i.command = brvm_pkg::CMD_JUMP;
			i.immediate = $urandom_range(0, 100);
		end
		return i;
	endfunction

	task automatic drain();
		while (instr_q.size() != 0 || status_q.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_length(logic [15:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		prog_len = {48'd0, v};
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// driver
	int  in_gap;
	logic in_took;
	logic in_calm;

	always @(posedge clk) in_took <= s_tvalid && s_tready;

	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_took) begin
				// hold the word
			end else if (in_gap > 0) begin
				s_tvalid <= 1'b0;
				in_gap = in_gap - 1;
			end else if (instr_q.size() != 0) begin
				brvm_pkg::instr_t nx;
				nx = instr_q.pop_front();
				s_tdata <= {2'b00, nx.immediate, nx.src2_reg, nx.src1_reg, nx.dest_reg,
					nx.is_signed, nx.source_width_code, nx.width_code, nx.command};
				s_tvalid <= 1'b1;
				if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
				in_gap = in_calm ? 0 : $urandom_range(0, 15);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	int   out_gap;
	logic out_took;
	logic out_calm;

	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (arst_n) begin
			if (out_took) begin
				if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
				out_gap = out_calm ? 0 : $urandom_range(0, 15);
			end
			if (out_gap > 0) begin
				rdy = 1'b0;
				out_gap = out_gap - 1;
			end
			m_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		vm_status_t want;
		out_took <= m_tvalid && m_tready;
		if (m_tvalid && m_tready) begin
			if (status_q.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				errors = errors + 1;
			end else begin
				want = status_q.pop_front();
				if (m_tdata[63:0] !== want.next_ip) begin
					$error("next_ip: expected %h, got %h", want.next_ip, m_tdata[63:0]);
					errors = errors + 1;
				end
				if (m_tdata[64] !== want.halted) begin
					$error("halted: expected %b, got %b", want.halted, m_tdata[64]);
					errors = errors + 1;
				end
				if (m_tdata[65] !== want.error) begin
					$error("error: expected %b, got %b", want.error, m_tdata[65]);
					errors = errors + 1;
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cnt = 0;
		else
			stall_cnt = stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		stall_cnt = 0;
		in_gap = 0;
		out_gap = 0;
		in_calm = 1'b0;
		out_calm = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		for (int k = 0; k < 16; k++) regs[k] = '0;
		vm_ip = '0;
		vm_halt = 1'b0;
		vm_err = 1'b0;
		prog_len = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_length(16'hffff);
		// directed: extremes and corner cases
		send(make_instr(brvm_pkg::CMD_CONST, 2'd3, 0, 0, 4'd0, 0, 0, 64'hffff_ffff_ffff_ffff));
		send(make_instr(brvm_pkg::CMD_CONST, 2'd0, 0, 0, 4'd1, 0, 0, 64'h0000_0000_0000_0080));
		send(make_instr(brvm_pkg::CMD_CONST, 2'd0, 0, 0, 4'd2, 0, 0, 64'h0000_0000_0000_00ff));
		send(make_instr(brvm_pkg::CMD_CONST, 2'd3, 0, 0, 4'd15, 0, 0, 64'h8000_0000_0000_0000));
		// most negative over minus one, 8 and 64 bits
		send(make_instr(brvm_pkg::CMD_DIV, 2'd0, 0, 1, 4'd3, 4'd1, 4'd2, 0));
		send(make_instr(brvm_pkg::CMD_MOD, 2'd0, 0, 1, 4'd4, 4'd1, 4'd2, 0));
		send(make_instr(brvm_pkg::CMD_DIV, 2'd3, 0, 1, 4'd5, 4'd15, 4'd0, 0));
		// division by zero
		send(make_instr(brvm_pkg::CMD_DIV, 2'd2, 0, 0, 4'd6, 4'd0, 4'd14, 0));
		send(make_instr(brvm_pkg::CMD_MOD, 2'd1, 0, 1, 4'd7, 4'd1, 4'd14, 0));
		send(make_instr(brvm_pkg::CMD_MUL, 2'd3, 0, 0, 4'd8, 4'd0, 4'd0, 0));
		send(make_instr(brvm_pkg::CMD_ADD, 2'd1, 0, 0, 4'd9, 4'd0, 4'd2, 0));
		send(make_instr(brvm_pkg::CMD_SUB, 2'd2, 0, 0, 4'd10, 4'd14, 4'd0, 0));
		send(make_instr(brvm_pkg::CMD_LT, 2'd0, 0, 1, 4'd11, 4'd1, 4'd2, 0));
		send(make_instr(brvm_pkg::CMD_GT, 2'd0, 0, 0, 4'd12, 4'd1, 4'd2, 0));
		send(make_instr(brvm_pkg::CMD_LE, 2'd3, 0, 1, 4'd13, 4'd15, 4'd0, 0));
		send(make_instr(brvm_pkg::CMD_GE, 2'd3, 0, 0, 4'd13, 4'd15, 4'd0, 0));
		send(make_instr(brvm_pkg::CMD_EQ, 2'd2, 0, 1, 4'd12, 4'd0, 4'd0, 0));
		send(make_instr(brvm_pkg::CMD_SEXT, 2'd3, 2'd0, 0, 4'd14, 4'd1, 0, 0));
		// extension sources wider and narrower than the destination
		send(make_instr(brvm_pkg::CMD_SEXT, 2'd1, 2'd3, 0, 4'd9, 4'd0, 0, 0));
		send(make_instr(brvm_pkg::CMD_ZEXT, 2'd3, 2'd2, 0, 4'd8, 4'd0, 0, 0));
		// condition register with only upper bits set, then with all bits set
		send(make_instr(brvm_pkg::CMD_JT, 0, 0, 0, 4'd15, 0, 0, 64'd200));
		send(make_instr(brvm_pkg::CMD_JF, 0, 0, 0, 4'd15, 0, 0, 64'd300));
		send(make_instr(brvm_pkg::CMD_JT, 0, 0, 0, 4'd0, 0, 0, 64'd500));
		send(make_instr(brvm_pkg::CMD_JUMP, 0, 0, 0, 0, 0, 0, 64'd16));
		for (int n = 0; n < 900; n++) send(rand_instr());
		drain();

		write_length(16'd30000);
		for (int n = 0; n < 950; n++) send(rand_instr());
		drain();

		// bounds: exact fit passes, the next one runs past the end
		send(make_instr(brvm_pkg::CMD_JUMP, 0, 0, 0, 0, 0, 0, 64'd40));
		drain();
		write_length(16'd53);
		send(make_instr(brvm_pkg::CMD_ADD, 2'd3, 0, 0, 4'd1, 4'd0, 4'd0, 0));
		send(make_instr(brvm_pkg::CMD_JUMP, 0, 0, 0, 0, 0, 0, 64'h0123_4567_89ab_cdef));
		send(make_instr(brvm_pkg::CMD_ADD, 2'd3, 0, 0, 4'd1, 4'd0, 4'd0, 0));
		drain();

		write_length(16'd0);
		// sticky flags: these are ignored
		send(make_instr(brvm_pkg::CMD_HALT, 0, 0, 0, 0, 0, 0, 0));
		send(make_instr(CMD_ILLEGAL, 0, 0, 0, 0, 0, 0, 0));
		send(make_instr(5'd31, 2'd3, 2'd3, 1, 4'd15, 4'd15, 4'd15, 64'hffff_ffff_ffff_ffff));
		drain();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
